// ===== rtl/mstw_pkg.sv =====
// shared constants for the spanning tree weight block
// no dependencies
package mstw_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;
    localparam int WEIGHT_BITS  = 32;

    localparam int WEIGHT_W = 32;
    localparam int END_W    = 10;
    localparam int VCNT_W   = 11;
    localparam int SUM_W    = 42;
    localparam int TAKEN_W  = 10;
    localparam int RANK_W   = 5;

endpackage

// ===== rtl/mstw_ram.sv =====
// generic single-port-write, single-read synchronous ram
// registered read data, no dependencies
module mstw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/minimum_spanning_tree_weight_top.sv =====
// kruskal minimum spanning tree weight: edge load, merge sort, union-find walk
// depends on mstw_pkg and mstw_ram
//
//  channel  dir  handshake            contents
//  s_       in   s_tvalid/s_tready    tdata: weight, end_a, end_b; tlast: last edge
//  m_       out  m_tvalid/m_tready    tdata: total_weight, edges_taken
//  cfg_     in   cfg_valid/cfg_ready  vertex_count
//
// edges load one per cycle; the last edge starts a run
// run: vertex init sweep over all MAX_VERTICES entries, ceil(log2(n)) merge passes
// (both heads reread per compare), then per edge a find and a path compression
// walk on each endpoint and a link with an optional rank increment
// input and cfg are stalled for the whole run; the result waits in an output
// register, so loading resumes while it is held and the next run stalls on it
module minimum_spanning_tree_weight_top #(
    parameter int MAX_VERTICES = mstw_pkg::MAX_VERTICES,
    parameter int MAX_EDGES    = mstw_pkg::MAX_EDGES,
    parameter int WEIGHT_BITS  = mstw_pkg::WEIGHT_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // edge_weight[31:0], end_a[41:32], end_b[51:42], zero pad
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // total_weight[41:0], edges_taken[51:42], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

    localparam int END_W  = mstw_pkg::END_W;
    localparam int RANK_W = mstw_pkg::RANK_W;
    localparam int WB     = (WEIGHT_BITS < mstw_pkg::WEIGHT_W) ? WEIGHT_BITS
                                                               : mstw_pkg::WEIGHT_W;
    localparam int EA_W   = $clog2(MAX_EDGES);
    localparam int EC_W   = $clog2(MAX_EDGES + 1);
    localparam int VA_W   = $clog2(MAX_VERTICES);
    localparam int EW     = WB + 2 * END_W;
    localparam int PW     = VA_W + RANK_W;

    typedef enum logic [4:0] {
        S_LOAD, S_INIT, S_MPASS, S_MRD, S_MWAIT, S_MCMP, S_MCOPYR, S_MCOPYW,
        S_EREAD, S_EWAIT, S_ECHK, S_FRD, S_FWAIT, S_FSTEP, S_CRD, S_CWAIT,
        S_CSTEP, S_UNION, S_RANKUP, S_OUT
    } state_t;

    state_t state_reg;

    logic [10:0]          vcnt_reg;
    logic [EC_W-1:0]      ecount_reg;
    logic [EC_W:0]        width_reg, lo_reg, i_reg, j_reg, k_reg, mid_reg, hi_reg;
    logic                 src_reg;
    logic [EW-1:0]        ei_reg, ej_reg;
    logic                 side_reg;
    logic [EC_W-1:0]      idx_reg;
    logic [VA_W-1:0]      vb_reg, ra_reg, cur_reg, root_reg, fv_reg;
    logic                 which_reg;
    logic [RANK_W-1:0]    rka_reg, rkr_reg, rka_inc;
    logic [VA_W:0]        init_reg;
    logic [63:0]          sum_reg;
    logic [10:0]          taken_reg;
    logic [mstw_pkg::SUM_W-1:0]   out_sum_reg;
    logic [mstw_pkg::TAKEN_W-1:0] out_taken_reg;
    logic                 mvalid_reg;
    logic [11:0]          neff;

    // edge memory: lower and upper halves ping-pong between merge passes
    logic            e_we;
    logic [EA_W:0]   e_wa, e_ra;
    logic [EW-1:0]   e_wd, erd;
    logic            p_we;
    logic [VA_W-1:0] p_wa, p_ra;
    logic [PW-1:0]   p_wd, p_rd;
    logic [VA_W-1:0] p_par;
    logic [RANK_W-1:0] p_rank;

    logic            s_fire, lt;
    logic [EW-1:0]   s_edge;
    logic [VA_W-1:0] ea_v, eb_v;
    logic            ea_ok, eb_ok;

    mstw_ram #(.WIDTH(EW), .DEPTH(2 * MAX_EDGES)) u_edge (
        .aclk(aclk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(erd));
    mstw_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_forest (
        .aclk(aclk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

    assign p_par   = p_rd[VA_W-1:0];
    assign p_rank  = p_rd[PW-1:VA_W];
    assign rka_inc = rka_reg + 1'b1;

    function automatic logic edge_lt(input logic [EW-1:0] p, input logic [EW-1:0] q);
        logic [WB-1:0] pw, qw;
        logic [END_W-1:0] pa, qa, pb, qb;
        pw = p[WB-1:0];
        qw = q[WB-1:0];
        pa = p[WB +: END_W];
        qa = q[WB +: END_W];
        pb = p[WB+END_W +: END_W];
        qb = q[WB+END_W +: END_W];
        if (pw != qw) return pw < qw;
        if (pa != qa) return pa < qa;
        return pb < qb;
    endfunction

    always_comb begin
        if (vcnt_reg == 11'd0) neff = 12'd1;
        else if ({1'b0, vcnt_reg} > 12'(MAX_VERTICES)) neff = 12'(MAX_VERTICES);
        else neff = {1'b0, vcnt_reg};
    end

    assign s_tready  = (state_reg == S_LOAD);
    assign cfg_ready = (state_reg == S_LOAD);
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = {4'd0, out_taken_reg, out_sum_reg};

    assign s_fire = s_tvalid && s_tready;
    assign s_edge = {s_tdata[51:42], s_tdata[41:32], s_tdata[WB-1:0]};
    assign lt     = edge_lt(ej_reg, ei_reg);

    assign ea_v  = erd[WB +: VA_W];
    assign eb_v  = erd[WB+END_W +: VA_W];
    assign ea_ok = {2'b0, erd[WB +: END_W]} < neff;
    assign eb_ok = {2'b0, erd[WB+END_W +: END_W]} < neff;

    // memory port control
    always_comb begin
        e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
        p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
        case (state_reg)
            S_LOAD: begin
                e_we = s_fire && (ecount_reg < EC_W'(MAX_EDGES));
                e_wa = {1'b0, ecount_reg[EA_W-1:0]};
                e_wd = s_edge;
            end
            S_INIT: begin
                p_we = 1'b1;
                p_wa = init_reg[VA_W-1:0];
                p_wd = {{RANK_W{1'b0}}, init_reg[VA_W-1:0]};
            end
            S_MRD, S_MCOPYR: begin
                e_ra = {src_reg, (side_reg ? j_reg[EA_W-1:0] : i_reg[EA_W-1:0])};
            end
            S_MCMP, S_MCOPYW: begin
                e_we = 1'b1;
                e_wa = {~src_reg, k_reg[EA_W-1:0]};
                e_wd = (state_reg == S_MCOPYW) ? erd : (lt ? ej_reg : ei_reg);
            end
            S_EREAD, S_EWAIT: e_ra = {src_reg, idx_reg[EA_W-1:0]};
            S_FRD, S_FWAIT, S_CRD, S_CWAIT: p_ra = cur_reg;
            S_CSTEP: begin
                p_we = (p_par != root_reg);
                p_wa = cur_reg;
                p_wd = {p_rank, root_reg};
            end
            S_UNION: begin
                p_we = 1'b1;
                if (rka_reg < rkr_reg) begin
                    p_wa = ra_reg; p_wd = {rka_reg, root_reg};
                end else begin
                    p_wa = root_reg; p_wd = {rkr_reg, ra_reg};
                end
            end
            S_RANKUP: begin
                p_we = 1'b1; p_wa = ra_reg; p_wd = {rka_inc, ra_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_LOAD;
            vcnt_reg   <= 11'd1024;
            ecount_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            if (mvalid_reg && m_tready) mvalid_reg <= 1'b0;
            case (state_reg)
                S_LOAD: begin
                    if (cfg_valid) vcnt_reg <= cfg_data;
                    if (s_fire) begin
                        if (ecount_reg < EC_W'(MAX_EDGES)) ecount_reg <= ecount_reg + 1'b1;
                        if (s_tlast) begin
                            init_reg  <= '0;
                            state_reg <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    init_reg <= init_reg + 1'b1;
                    if (init_reg == (VA_W+1)'(MAX_VERTICES - 1)) begin
                        width_reg <= (EC_W+1)'(1);
                        src_reg   <= 1'b0;
                        lo_reg    <= '0;
                        state_reg <= S_MPASS;
                        sum_reg   <= '0;
                        taken_reg <= '0;
                    end
                end
                S_MPASS: begin
                    if (width_reg >= {1'b0, ecount_reg}) begin
                        idx_reg   <= '0;
                        state_reg <= S_EREAD;
                    end else if (lo_reg >= {1'b0, ecount_reg}) begin
                        lo_reg    <= '0;
                        width_reg <= width_reg << 1;
                        src_reg   <= !src_reg;
                    end else begin
                        i_reg <= lo_reg;
                        k_reg <= lo_reg;
                        mid_reg <= (lo_reg + width_reg > {1'b0, ecount_reg}) ?
                                   {1'b0, ecount_reg} : lo_reg + width_reg;
                        hi_reg <= (lo_reg + (width_reg << 1) > {1'b0, ecount_reg}) ?
                                  {1'b0, ecount_reg} : lo_reg + (width_reg << 1);
                        j_reg <= (lo_reg + width_reg > {1'b0, ecount_reg}) ?
                                 {1'b0, ecount_reg} : lo_reg + width_reg;
                        side_reg  <= 1'b0;
                        state_reg <= S_MRD;
                    end
                end
                S_MRD: begin
                    if (i_reg < mid_reg && j_reg < hi_reg) begin
                        state_reg <= S_MWAIT;
                    end else if (i_reg < mid_reg) begin
                        side_reg  <= 1'b0;
                        state_reg <= S_MCOPYR;
                    end else if (j_reg < hi_reg) begin
                        side_reg  <= 1'b1;
                        state_reg <= S_MCOPYR;
                    end else begin
                        lo_reg    <= hi_reg;
                        state_reg <= S_MPASS;
                    end
                end
                S_MWAIT: begin
                    if (side_reg) begin
                        ej_reg    <= erd;
                        state_reg <= S_MCMP;
                    end else begin
                        ei_reg    <= erd;
                        side_reg  <= 1'b1;
                        state_reg <= S_MRD;
                    end
                end
                S_MCMP: begin
                    k_reg <= k_reg + 1'b1;
                    if (lt) j_reg <= j_reg + 1'b1;
                    else i_reg <= i_reg + 1'b1;
                    side_reg  <= 1'b0;
                    state_reg <= S_MRD;
                end
                S_MCOPYR: state_reg <= S_MCOPYW;
                S_MCOPYW: begin
                    k_reg <= k_reg + 1'b1;
                    if (side_reg) j_reg <= j_reg + 1'b1;
                    else i_reg <= i_reg + 1'b1;
                    state_reg <= S_MRD;
                end
                S_EREAD: begin
                    if (idx_reg >= ecount_reg || {1'b0, taken_reg} + 12'd1 >= neff)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_EWAIT;
                end
                S_EWAIT: state_reg <= S_ECHK;
                S_ECHK: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (ea_ok && eb_ok && ea_v != eb_v) begin
                        vb_reg    <= eb_v;
                        ei_reg    <= erd;
                        cur_reg   <= ea_v;
                        fv_reg    <= ea_v;
                        which_reg <= 1'b0;
                        state_reg <= S_FRD;
                    end else begin
                        state_reg <= S_EREAD;
                    end
                end
                S_FRD: state_reg <= S_FWAIT;
                S_FWAIT: state_reg <= S_FSTEP;
                S_FSTEP: begin
                    if (p_par == cur_reg) begin
                        root_reg  <= cur_reg;
                        rkr_reg   <= p_rank;
                        cur_reg   <= fv_reg;
                        state_reg <= S_CRD;
                    end else begin
                        cur_reg   <= p_par;
                        state_reg <= S_FRD;
                    end
                end
                S_CRD: state_reg <= S_CWAIT;
                S_CWAIT: state_reg <= S_CSTEP;
                S_CSTEP: begin
                    if (p_par == root_reg) begin
                        if (!which_reg) begin
                            ra_reg    <= root_reg;
                            rka_reg   <= rkr_reg;
                            which_reg <= 1'b1;
                            cur_reg   <= vb_reg;
                            fv_reg    <= vb_reg;
                            state_reg <= S_FRD;
                        end else if (root_reg == ra_reg) begin
                            state_reg <= S_EREAD;
                        end else begin
                            state_reg <= S_UNION;
                        end
                    end else begin
                        cur_reg   <= p_par;
                        state_reg <= S_CRD;
                    end
                end
                S_UNION: begin
                    sum_reg   <= sum_reg + 64'(ei_reg[WB-1:0]);
                    taken_reg <= taken_reg + 1'b1;
                    state_reg <= (rka_reg == rkr_reg) ? S_RANKUP : S_EREAD;
                end
                S_RANKUP: state_reg <= S_EREAD;
                S_OUT: begin
                    if (!mvalid_reg) begin
                        out_sum_reg   <= sum_reg[mstw_pkg::SUM_W-1:0];
                        out_taken_reg <= taken_reg[mstw_pkg::TAKEN_W-1:0];
                        mvalid_reg    <= 1'b1;
                        ecount_reg    <= '0;
                        state_reg     <= S_LOAD;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
